// ----- src/one_button_motor_mode_controller_assert.svh -----
// Assertion macros for the one-button motor and LED controller.
`ifndef ONE_BUTTON_MOTOR_MODE_CONTROLLER_ASSERT_SVH
`define ONE_BUTTON_MOTOR_MODE_CONTROLLER_ASSERT_SVH

// Check that cons holds in every cycle in which ante holds.
`define OBMMC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that expr never holds.
`define OBMMC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ----- src/obmmc_pkg.sv -----
`default_nettype none

package obmmc_pkg;

	typedef struct packed {
		logic req_type;
		logic key_pressed;
	} item_t;

	typedef struct packed {
		logic       led_on;
		logic       motor_pin;
		logic       aux_pin;
		logic [2:0] mode;
	} result_t;

	localparam logic       ReqTick      = 1'b0;
	localparam logic       ReqPwm       = 1'b1;

	localparam logic [7:0] HoldMin      = 8'd100;
	localparam logic [7:0] HoldSat      = 8'd200;
	localparam logic [4:0] PhaseMax     = 5'd16;
	localparam logic [3:0] PwmSteps     = 4'd10;
	localparam logic [3:0] DutyReset    = 4'd5;
	localparam logic [2:0] ModeOff      = 3'd0;
	localparam logic [2:0] ModeSteady   = 3'd1;
	localparam logic [2:0] ModeLast     = 3'd5;
	localparam int         LedBand      = 500;
	localparam int         LedBands     = 10;

	function automatic logic [12:0] led_load(input logic [2:0] mode);
		logic [12:0] v;
		case (mode)
			3'd1:    v = 13'd1000;
			3'd2:    v = 13'd2000;
			3'd3:    v = 13'd3000;
			3'd4:    v = 13'd4000;
			3'd5:    v = 13'd5000;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] stop_time(input logic [2:0] mode);
		logic [4:0] v;
		case (mode)
			3'd1:    v = 5'd9;
			3'd2:    v = 5'd6;
			3'd3:    v = 5'd4;
			3'd4:    v = 5'd2;
			default: v = 5'd0;
		endcase
		return v;
	endfunction

	// Odd 500-tick band of (count - 1); count is nonzero.
	function automatic logic band_odd(input logic [12:0] count);
		logic [12:0] v;
		logic        odd;
		v   = count - 13'd1;
		odd = 1'b0;
		for (int b = 1; b < LedBands; b += 2) begin
			if (v >= 13'(b * LedBand) && v < 13'((b + 1) * LedBand)) begin
				odd = 1'b1;
			end
		end
		return odd;
	endfunction

endpackage

`default_nettype wire

// ----- src/obmmc_core.sv -----
`default_nettype none

module obmmc_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    fire,
	input  obmmc_pkg::item_t       item,
	input  wire                    cfg_we,
	input  wire [3:0]              cfg_data,
	output obmmc_pkg::result_t     result
);

	logic [3:0]  duty_q;
	logic [7:0]  hold_q,  n_hold;
	logic [2:0]  mode_q,  n_mode;
	logic [12:0] cd_q,    n_cd;
	logic [4:0]  phase_q, n_phase;
	logic        me_q,    n_me;
	logic [3:0]  pwm_q,   n_pwm;
	logic        led_q,   n_led;
	logic        mot_q,   n_mot;
	logic        aux_q,   n_aux;
	logic        click;

	always_comb begin
		n_hold  = hold_q;
		n_mode  = mode_q;
		n_cd    = cd_q;
		n_phase = phase_q;
		n_me    = me_q;
		n_pwm   = pwm_q;
		n_led   = led_q;
		n_mot   = mot_q;
		n_aux   = aux_q;
		click   = 1'b0;
		if (item.req_type == obmmc_pkg::ReqTick) begin
			if (mode_q == obmmc_pkg::ModeOff && hold_q == 8'd0) begin
				n_led = 1'b0;
				n_mot = 1'b0;
				n_aux = 1'b0;
			end
			if (item.key_pressed) begin
				if (hold_q < obmmc_pkg::HoldSat) begin
					n_hold = hold_q + 8'd1;
				end
			end else begin
				click  = (hold_q >= obmmc_pkg::HoldMin);
				n_hold = 8'd0;
			end
			if (click) begin
				if (mode_q >= obmmc_pkg::ModeLast) begin
					n_mode = obmmc_pkg::ModeOff;
					n_me   = 1'b0;
					n_led  = 1'b0;
					n_mot  = 1'b0;
					n_aux  = 1'b0;
				end else begin
					n_mode = mode_q + 3'd1;
				end
				n_cd = obmmc_pkg::led_load(n_mode);
			end
			if (n_mode != obmmc_pkg::ModeOff) begin
				if (n_mode > obmmc_pkg::ModeSteady) begin
					n_led = (n_cd == 13'd0) ? 1'b1 : obmmc_pkg::band_odd(n_cd);
					if (n_cd != 13'd0) begin
						n_cd = n_cd - 13'd1;
					end
				end else begin
					n_led = 1'b1;
				end
				n_phase = (phase_q >= obmmc_pkg::PhaseMax) ? 5'd0 : phase_q + 5'd1;
				if (obmmc_pkg::stop_time(n_mode) > n_phase) begin
					n_me  = 1'b0;
					n_mot = 1'b0;
				end else begin
					n_me  = 1'b1;
					n_aux = 1'b1;
				end
			end
		end else if (me_q) begin
			n_mot = (pwm_q < duty_q);
			n_pwm = (pwm_q >= obmmc_pkg::PwmSteps - 4'd1) ? 4'd0 : pwm_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q  <= obmmc_pkg::DutyReset;
			hold_q  <= 8'd0;
			mode_q  <= obmmc_pkg::ModeOff;
			cd_q    <= 13'd0;
			phase_q <= 5'd0;
			me_q    <= 1'b0;
			pwm_q   <= 4'd0;
			led_q   <= 1'b0;
			mot_q   <= 1'b0;
			aux_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				duty_q <= cfg_data;
			end
			if (fire) begin
				hold_q  <= n_hold;
				mode_q  <= n_mode;
				cd_q    <= n_cd;
				phase_q <= n_phase;
				me_q    <= n_me;
				pwm_q   <= n_pwm;
				led_q   <= n_led;
				mot_q   <= n_mot;
				aux_q   <= n_aux;
			end
		end
	end

	assign result.led_on    = n_led;
	assign result.motor_pin = n_mot;
	assign result.aux_pin   = n_aux;
	assign result.mode      = n_mode;

endmodule

`default_nettype wire

// ----- src/obmmc_out.sv -----
`default_nettype none

module obmmc_out (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    load,
	input  obmmc_pkg::result_t     data,
	output logic                   space,
	output logic                   result_valid,
	input  wire                    result_stall,
	output obmmc_pkg::result_t     result
);

	logic               valid_q;
	obmmc_pkg::result_t data_q;

	assign space = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

`default_nettype wire

// ----- src/one_button_motor_mode_controller.sv -----
// One-button motor and LED controller.
// Request channel: item_valid / item_stall / item. A request is taken at a
// clock edge with item_valid high and item_stall low. A request is either a
// millisecond tick carrying the button level or a fast PWM step.
// Result channel: result_valid / result_stall / result, one result per
// request, in order, holding LED, motor pin, aux pin and current mode.
// Config channel: cfg_valid / cfg_ready / cfg_data writes the PWM duty
// (steps out of ten); cfg_ready is always high. Write only while idle.
// A request is held in the input register; its state update and result are
// formed combinationally from it, and the result is then registered in the
// output register, which drives result_valid; a stalled output holds it back.
// Throughput: one request per cycle while results are not stalled.
// Reset: arst_n clears the control state, pins low, mode 0, duty 5; no results pending.
// Stall: a stalled result is held; one more request can enter the input
// register behind it, after which item_stall rises until result_stall drops.
`default_nettype none
`include "one_button_motor_mode_controller_assert.svh"

module one_button_motor_mode_controller (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_stall,
	input  obmmc_pkg::item_t       item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output obmmc_pkg::result_t     result,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [3:0]              cfg_data
);

	logic               valid_s1;
	obmmc_pkg::item_t   item_s1;
	obmmc_pkg::result_t next_result;
	logic               space;
	logic               advance;
	logic               res_mode_ok;
	logic               res_off;
	logic               pins_low;
	logic               res_motor;
	logic               out_busy;

	assign advance    = valid_s1 && space;
	assign item_stall = valid_s1 && !space;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	obmmc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (next_result)
	);

	obmmc_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.data         (next_result),
		.space        (space),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign res_mode_ok = result.mode <= obmmc_pkg::ModeLast;
	assign res_off     = result_valid && result.mode == obmmc_pkg::ModeOff;
	assign pins_low    = !result.led_on && !result.motor_pin && !result.aux_pin;
	assign res_motor   = result_valid && result.motor_pin;
	assign out_busy    = result_valid && result_stall;

	`OBMMC_ASSERT_IMPLIES(a_mode_range, clk, arst_n, result_valid, res_mode_ok, "mode out of range")
	`OBMMC_ASSERT_IMPLIES(a_off_pins, clk, arst_n, res_off, pins_low, "pins set in mode off")
	`OBMMC_ASSERT_IMPLIES(a_motor_aux, clk, arst_n, res_motor, result.aux_pin, "motor without aux")
	`OBMMC_ASSERT_NEVER(a_stall_cause, clk, arst_n, item_stall && !out_busy, "spurious stall")

endmodule

`default_nettype wire
